[sv/rcm_pkg.sv]
// ----------------------------------------------------------------------------
// rcm_pkg: shared types and constants for the rotor cipher machine
// Item layouts, opcodes, table select codes, register indexes and the
// sequencer state type.
// ----------------------------------------------------------------------------
package rcm_pkg;

  localparam int LetterW    = 5;
  localparam int NumPos     = 4;   // position slots carried on the result
  localparam int StepRotors = 3;   // only rotors 0..2 ever step
  localparam int CfgIdxW    = 2;
  localparam int CfgDataW   = 26;
  localparam int TdataW     = 32;

  typedef logic [LetterW-1:0] rcm_letter_t;
  typedef logic [NumPos-1:0][LetterW-1:0] rcm_pos_t;

  typedef enum logic [2:0] {
    OpEncode   = 3'd0,
    OpStepFwd  = 3'd1,
    OpStepBack = 3'd2,
    OpLoad     = 3'd3,
    OpSetPos   = 3'd4
  } rcm_op_e;

  // table_select codes
  localparam logic [3:0] SelPlug     = 4'd0;
  localparam logic [3:0] SelFwdFirst = 4'd1;
  localparam logic [3:0] SelFwdLast  = 4'd4;
  localparam logic [3:0] SelInvFirst = 4'd5;
  localparam logic [3:0] SelInvLast  = 4'd8;
  localparam logic [3:0] SelRefl     = 4'd9;

  typedef enum logic [CfgIdxW-1:0] {
    CfgRotorCount  = 2'd0,
    CfgRingOffsets = 2'd1,
    CfgFastNotch   = 2'd2,
    CfgMiddleNotch = 2'd3
  } rcm_cfg_e;

  typedef enum logic [1:0] {
    StIdle,
    StExec,
    StLook,
    StWb
  } rcm_state_e;

  // input item, op in the lowest bits
  typedef struct packed {
    logic [4:0] position_value;
    logic [1:0] rotor_select;
    logic [4:0] table_value;
    logic [4:0] table_index;
    logic [3:0] table_select;
    logic [4:0] letter;
    logic [2:0] op;
  } rcm_item_t;

  // result item, cipher_letter in the lowest bits
  typedef struct packed {
    logic       input_error;
    logic [4:0] fourth_position;
    logic [4:0] slow_position;
    logic [4:0] middle_position;
    logic [4:0] fast_position;
    logic [4:0] cipher_letter;
  } rcm_result_t;

  // command from the sequencer to the rotor bank
  typedef struct packed {
    logic       step_fwd;
    logic       step_back;
    logic       set_pos;
    logic [1:0] sel;
    logic [4:0] value;
  } rcm_rotor_cmd_t;

endpackage

[sv/rcm_table_mem.sv]
// ----------------------------------------------------------------------------
// rcm_table_mem: wiring table store
// One write port, one read port with registered read data. Holds the
// plugboard, forward and inverse rotor wirings and the reflector.
// ----------------------------------------------------------------------------
module rcm_table_mem
  import rcm_pkg::*;
#(
  parameter int AddrW = 9
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  rcm_letter_t      wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output rcm_letter_t      rdata_o
);

  localparam int Depth = 1 << AddrW;

  rcm_letter_t mem_q [Depth];
  rcm_letter_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[sv/rcm_rotor_bank.sv]
// ----------------------------------------------------------------------------
// rcm_rotor_bank: rotor position registers and stepping logic
// Steps forward with the middle rotor double step, steps back by the
// reverse rule, or loads one position.
// ----------------------------------------------------------------------------
module rcm_rotor_bank
  import rcm_pkg::*;
#(
  parameter int ALPHABET_SIZE = 26
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  rcm_rotor_cmd_t cmd_i,
  input  logic [25:0]    fast_notch_i,
  input  logic [25:0]    middle_notch_i,
  output rcm_pos_t       pos_o
);

  localparam logic [5:0] Alpha = 6'(ALPHABET_SIZE);

  rcm_pos_t pos_q, pos_d;

  function automatic rcm_letter_t wrap_inc(input rcm_letter_t p);
    logic [5:0] s;
    s = {1'b0, p} + 6'd1;
    return (s >= Alpha) ? '0 : s[4:0];
  endfunction

  function automatic rcm_letter_t wrap_dec(input rcm_letter_t p);
    logic [5:0] s;
    s = Alpha - 6'd1;
    return (p == '0) ? s[4:0] : p - 5'd1;
  endfunction

  function automatic logic notch(input int r, input rcm_letter_t p,
                                 input logic [31:0] fm, input logic [31:0] mm);
    logic n;
    n = 1'b0;
    if (r == 0) n = fm[p];
    else if (r == 1) n = mm[p];
    return n;
  endfunction

  always_comb begin
    logic [31:0] fm;
    logic [31:0] mm;
    logic        carry;
    logic        nc;
    fm    = {6'd0, fast_notch_i};
    mm    = {6'd0, middle_notch_i};
    pos_d = pos_q;
    carry = 1'b1;
    nc    = 1'b0;
    if (cmd_i.step_fwd) begin
      for (int r = 0; r < StepRotors; r++) begin
        if (carry) begin
          nc = notch(r, pos_q[r], fm, mm);
          if (r == 0 && notch(1, pos_q[1], fm, mm)) nc = 1'b1;
          pos_d[r] = wrap_inc(pos_q[r]);
          carry = nc;
        end
      end
    end else if (cmd_i.step_back) begin
      for (int r = 0; r < StepRotors; r++) begin
        if (carry) begin
          pos_d[r] = wrap_dec(pos_q[r]);
          nc = notch(r, pos_d[r], fm, mm);
          if (r == 0 && notch(0, wrap_dec(pos_d[0]), fm, mm) &&
              notch(1, wrap_dec(pos_q[1]), fm, mm)) nc = 1'b1;
          carry = nc;
        end
      end
    end else if (cmd_i.set_pos) begin
      pos_d[cmd_i.sel] = cmd_i.value;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
    end else begin
      pos_q <= pos_d;
    end
  end

  assign pos_o = pos_q;

endmodule

[sv/rcm_path_unit.sv]
// ----------------------------------------------------------------------------
// rcm_path_unit: shared modular unit of the signal path
// Removes the current rotor offset from a table read, forms the next
// rotor offset and the next table index, all modulo the alphabet size.
// ----------------------------------------------------------------------------
module rcm_path_unit
  import rcm_pkg::*;
#(
  parameter int ALPHABET_SIZE = 26
) (
  input  rcm_letter_t rdata_i,
  input  rcm_letter_t off_cur_i,
  input  logic        use_off_i,
  input  rcm_letter_t pos_next_i,
  input  rcm_letter_t ring_next_i,
  output rcm_letter_t x_o,
  output rcm_letter_t off_next_o,
  output rcm_letter_t idx_next_o
);

  localparam logic [5:0] Alpha = 6'(ALPHABET_SIZE);

  function automatic rcm_letter_t sub_mod(input rcm_letter_t a, input rcm_letter_t b);
    logic [5:0] d;
    d = {1'b0, a} + Alpha - {1'b0, b};
    if (d >= Alpha) d = d - Alpha;
    return d[4:0];
  endfunction

  function automatic rcm_letter_t add_mod(input rcm_letter_t a, input rcm_letter_t b);
    logic [5:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= Alpha) s = s - Alpha;
    return s[4:0];
  endfunction

  rcm_letter_t off_next;

  assign x_o        = sub_mod(rdata_i, off_cur_i);
  assign off_next   = use_off_i ? sub_mod(pos_next_i, ring_next_i) : '0;
  assign off_next_o = off_next;
  assign idx_next_o = add_mod(x_o, off_next);

endmodule

[sv/rotor_cipher_machine.sv]
// ----------------------------------------------------------------------------
// rotor_cipher_machine: rotor cipher with plugboard and reflector
// Steps the rotors and encodes one letter per encode item; other items
// step, load a wiring table entry or set a rotor position.
// ----------------------------------------------------------------------------
//
//  Channel  | Direction | Signals                              | Contents
//  ---------+-----------+--------------------------------------+---------------------
//  s_axis   | in        | s_axis_tvalid/tready/tdata[31:0]     | one command item
//  m_axis   | out       | m_axis_tvalid/tready/tdata[31:0]     | one result per item
//  cfg      | in        | cfg_valid_i/cfg_ready_o/index/data   | register writes
//
//  An encode item makes 2*n + 3 table lookups for n rotors in the path; they
//  run one a cycle through the single read port of the table memory. No item
//  is taken while one is in flight; a result waiting on a stalled m_axis
//  holds the block in write-back only when a second result is ready. Reset
//  clears the rotor positions and the registers; the tables are undefined
//  until loaded.
//
module rotor_cipher_machine
  import rcm_pkg::*;
#(
  parameter int ALPHABET_SIZE = 26,
  parameter int MAX_ROTORS    = 4
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // op, letter, table_select, table_index, table_value, rotor_select,
  // position_value (from bit 0 up), zero filled
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [TdataW-1:0]   s_axis_tdata,
  // cipher_letter, fast_position, middle_position, slow_position,
  // fourth_position, input_error (from bit 0 up), zero filled
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [TdataW-1:0]   m_axis_tdata,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  localparam int         SlotW    = $clog2(2 * MAX_ROTORS + 2);
  localparam int         AddrW    = SlotW + LetterW;
  localparam int         KW       = $clog2(2 * MAX_ROTORS + 4);
  localparam int         RotW     = $clog2(MAX_ROTORS);
  localparam logic [5:0] Alpha    = 6'(ALPHABET_SIZE);
  localparam logic [SlotW-1:0] PlugSlot = '0;
  localparam logic [SlotW-1:0] InvSlot0 = SlotW'(MAX_ROTORS + 1);
  localparam logic [SlotW-1:0] ReflSlot = SlotW'(2 * MAX_ROTORS + 1);
  localparam logic [2:0]       MaxRot   = 3'(MAX_ROTORS);

  // ring setting modulo the alphabet, as a small constant table
  function automatic rcm_letter_t ring_mod(input rcm_letter_t r);
    rcm_letter_t m;
    m = '0;
    for (int i = 0; i < 32; i++) begin
      if (r == 5'(i)) m = 5'(i % ALPHABET_SIZE);
    end
    return m;
  endfunction

  // Configuration registers
  logic [2:0]  rotor_count_q;
  logic [19:0] ring_offsets_q;
  logic [25:0] fast_notch_q;
  logic [25:0] middle_notch_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rotor_count_q  <= 3'd3;
      ring_offsets_q <= '0;
      fast_notch_q   <= '0;
      middle_notch_q <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CfgRotorCount:  rotor_count_q  <= cfg_data_i[2:0];
        CfgRingOffsets: ring_offsets_q <= cfg_data_i[19:0];
        CfgFastNotch:   fast_notch_q   <= cfg_data_i;
        CfgMiddleNotch: middle_notch_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Sequencer state
  rcm_state_e  state_q, state_d;
  rcm_item_t   item_q;
  logic [KW-1:0] k_q, k_d;
  rcm_letter_t off_q, off_d;
  rcm_letter_t cipher_q, cipher_d;
  logic        err_q, err_d;
  logic        out_valid_q, out_valid_d;
  rcm_result_t out_q, out_d;

  rcm_rotor_cmd_t rotor_cmd;
  rcm_pos_t       pos;

  logic             mem_we;
  logic [AddrW-1:0] mem_waddr;
  logic [AddrW-1:0] mem_raddr;
  rcm_letter_t      mem_rdata;

  // lookup sequencing
  logic [2:0]      n_rot;
  logic [KW-1:0]   nk, k_next, k_last;
  logic [RotW-1:0] rot_next;
  logic [SlotW-1:0] slot_next;
  logic            use_off;
  rcm_letter_t     x_cur, off_next, idx_next;

  assign s_axis_tready = (state_q == StIdle);

  always_comb begin
    if (rotor_count_q == 3'd0) n_rot = 3'd1;
    else if (rotor_count_q > MaxRot) n_rot = MaxRot;
    else n_rot = rotor_count_q;
  end

  assign nk     = KW'(n_rot);
  assign k_next = k_q + KW'(1);
  assign k_last = (nk << 1) + KW'(2);

  // Pick the table and the rotor of the next lookup: plugboard, forward
  // rotors upward, reflector, inverse rotors downward, plugboard again.
  always_comb begin
    logic [KW-1:0] t;
    t         = '0;
    rot_next  = '0;
    slot_next = PlugSlot;
    use_off   = 1'b0;
    if (k_next == '0) begin
      slot_next = PlugSlot;
    end else if (k_next <= nk) begin
      t         = k_next - KW'(1);
      rot_next  = t[RotW-1:0];
      slot_next = SlotW'(rot_next) + SlotW'(1);
      use_off   = 1'b1;
    end else if (k_next == nk + KW'(1)) begin
      slot_next = ReflSlot;
    end else if (k_next <= (nk << 1) + KW'(1)) begin
      t         = (nk << 1) + KW'(1) - k_next;
      rot_next  = t[RotW-1:0];
      slot_next = InvSlot0 + SlotW'(rot_next);
      use_off   = 1'b1;
    end
  end

  rcm_path_unit #(
    .ALPHABET_SIZE(ALPHABET_SIZE)
  ) u_path (
    .rdata_i    (mem_rdata),
    .off_cur_i  (off_q),
    .use_off_i  (use_off),
    .pos_next_i (pos[rot_next]),
    .ring_next_i(ring_mod(ring_offsets_q[5*rot_next +: 5])),
    .x_o        (x_cur),
    .off_next_o (off_next),
    .idx_next_o (idx_next)
  );

  // Load address: fold table_select into a memory slot
  always_comb begin
    logic [3:0] s;
    s = item_q.table_select;
    if (s == SelPlug) mem_waddr = {PlugSlot, item_q.table_index};
    else if (s == SelRefl) mem_waddr = {ReflSlot, item_q.table_index};
    else if (s <= SelFwdLast) mem_waddr = {SlotW'(s), item_q.table_index};
    else mem_waddr = {InvSlot0 + SlotW'(s - SelInvFirst), item_q.table_index};
  end

  // Next state and datapath control
  always_comb begin
    logic bad_load;
    logic [3:0] s;
    s           = item_q.table_select;
    state_d     = state_q;
    k_d         = k_q;
    off_d       = off_q;
    cipher_d    = cipher_q;
    err_d       = err_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    rotor_cmd   = '0;
    rotor_cmd.sel   = item_q.rotor_select;
    rotor_cmd.value = item_q.position_value;
    mem_we      = 1'b0;
    mem_raddr   = {slot_next, idx_next};
    bad_load    = ({1'b0, item_q.table_index} >= Alpha) ||
                  ({1'b0, item_q.table_value} >= Alpha) || (s > SelRefl) ||
                  (s >= SelFwdFirst && s <= SelFwdLast &&
                   (s - SelFwdFirst) >= 4'(MAX_ROTORS)) ||
                  (s >= SelInvFirst && s <= SelInvLast &&
                   (s - SelInvFirst) >= 4'(MAX_ROTORS));

    // drop the result once it is taken
    if (out_valid_q && m_axis_tready) out_valid_d = 1'b0;

    case (state_q)
      StIdle: begin
        if (s_axis_tvalid) state_d = StExec;
      end
      StExec: begin
        cipher_d = '0;
        err_d    = 1'b0;
        k_d      = '0;
        off_d    = '0;
        state_d  = StWb;
        case (item_q.op)
          OpEncode: begin
            if ({1'b0, item_q.letter} >= Alpha) begin
              err_d = 1'b1;
            end else begin
              // step first, then start at the plugboard
              rotor_cmd.step_fwd = 1'b1;
              mem_raddr = {PlugSlot, item_q.letter};
              state_d   = StLook;
            end
          end
          OpStepFwd:  rotor_cmd.step_fwd  = 1'b1;
          OpStepBack: rotor_cmd.step_back = 1'b1;
          OpLoad: begin
            if (bad_load) err_d = 1'b1;
            else mem_we = 1'b1;
          end
          OpSetPos: begin
            if ({1'b0, item_q.rotor_select} >= MaxRot ||
                {1'b0, item_q.position_value} >= Alpha) begin
              err_d = 1'b1;
            end else begin
              rotor_cmd.set_pos = 1'b1;
            end
          end
          default: err_d = 1'b1;
        endcase
      end
      StLook: begin
        // one table read a cycle; the last one is the plugboard
        if (k_q == k_last) begin
          cipher_d = x_cur;
          state_d  = StWb;
        end else begin
          k_d   = k_next;
          off_d = off_next;
        end
      end
      StWb: begin
        if (!out_valid_q || m_axis_tready) begin
          out_valid_d           = 1'b1;
          out_d.cipher_letter   = cipher_q;
          out_d.fast_position   = pos[0];
          out_d.middle_position = pos[1];
          out_d.slow_position   = pos[2];
          out_d.fourth_position = pos[3];
          out_d.input_error     = err_q;
          state_d               = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      item_q <= rcm_item_t'(s_axis_tdata[$bits(rcm_item_t)-1:0]);
    end
    k_q      <= k_d;
    off_q    <= off_d;
    cipher_q <= cipher_d;
    err_q    <= err_d;
    out_q    <= out_d;
  end

  rcm_rotor_bank #(
    .ALPHABET_SIZE(ALPHABET_SIZE)
  ) u_rotors (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (rotor_cmd),
    .fast_notch_i  (fast_notch_q),
    .middle_notch_i(middle_notch_q),
    .pos_o         (pos)
  );

  rcm_table_mem #(
    .AddrW(AddrW)
  ) u_tables (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(item_q.table_value),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {(TdataW - $bits(rcm_result_t))'(0), out_q};

endmodule

[tb/rcm_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rcm_checker: result predictor and comparator for rotor_cipher_machine
// Watches the register, command and result channels, keeps its own copy of
// the rotor positions, wiring tables and registers, and compares each result
// transfer field by field with the oldest predicted result.
// ----------------------------------------------------------------------------
module rcm_checker
  import rcm_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  input  logic                s_axis_tready,
  input  logic [TdataW-1:0]   s_axis_tdata,
  input  logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  input  logic [TdataW-1:0]   m_axis_tdata,
  input  logic                cfg_valid_i,
  input  logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output int                  mismatches_o,
  output int                  pending_o
);

  localparam int Alphabet  = 26;
  localparam int MaxRotors = 4;

  // register copies
  logic [2:0]  rotor_count;
  logic [19:0] ring_word;
  logic [25:0] fast_notches;
  logic [25:0] middle_notches;

  // machine state
  logic [4:0] wheel_pos [NumPos];
  logic [4:0] plug_map [Alphabet];
  logic [4:0] fwd_map [MaxRotors][Alphabet];
  logic [4:0] inv_map [MaxRotors][Alphabet];
  logic [4:0] refl_map [Alphabet];

  rcm_result_t predicted_q[$];
  int          mismatch_count;

  task automatic flag(string what, int got, int want);
    $display("%0t mismatch on %s: got %0d, want %0d", $time, what, got, want);
    mismatch_count++;
  endtask

  function automatic bit on_notch(int r, int p);
    case (r)
      0: return fast_notches[p];
      1: return middle_notches[p];
      default: return 1'b0;
    endcase
  endfunction

  function automatic int wrap_up(int p);
    return (p + 1 >= Alphabet) ? 0 : p + 1;
  endfunction

  function automatic int wrap_down(int p);
    return (p == 0) ? Alphabet - 1 : p - 1;
  endfunction

  // fast rotor always moves; middle moves on a fast notch or on its own notch
  task automatic advance_wheels();
    bit carry;
    bit next_carry;
    carry = 1'b1;
    for (int r = 0; r < StepRotors && carry; r++) begin
      next_carry = on_notch(r, wheel_pos[r]);
      if (r == 0 && on_notch(1, wheel_pos[1]))
        next_carry = 1'b1;
      wheel_pos[r] = 5'(wrap_up(wheel_pos[r]));
      carry = next_carry;
    end
  endtask

  // undo a step: a rotor landing on its notch pulls the next one back
  task automatic retreat_wheels();
    bit carry;
    carry = 1'b1;
    for (int r = 0; r < StepRotors && carry; r++) begin
      wheel_pos[r] = 5'(wrap_down(wheel_pos[r]));
      carry = on_notch(r, wheel_pos[r]);
      if (r == 0 && on_notch(0, wrap_down(wheel_pos[0])) &&
          on_notch(1, wrap_down(wheel_pos[1])))
        carry = 1'b1;
    end
  endtask

  function automatic int wheel_offset(int r);
    int ring;
    ring = int'(ring_word[5*r +: 5]) % Alphabet;
    return (int'(wheel_pos[r]) + Alphabet - ring) % Alphabet;
  endfunction

  function automatic int through_wheel(bit inverse, int r, int x);
    int shift;
    int entry;
    int v;
    shift = wheel_offset(r);
    entry = (x + shift) % Alphabet;
    v = inverse ? int'(inv_map[r][entry]) : int'(fwd_map[r][entry]);
    return (v % Alphabet + Alphabet - shift) % Alphabet;
  endfunction

  function automatic int encipher(int letter);
    int span;
    int x;
    span = int'(rotor_count);
    if (span < 1) span = 1;
    if (span > MaxRotors) span = MaxRotors;
    x = int'(plug_map[letter]) % Alphabet;
    for (int r = 0; r < span; r++)
      x = through_wheel(1'b0, r, x);
    x = int'(refl_map[x]) % Alphabet;
    for (int r = span - 1; r >= 0; r--)
      x = through_wheel(1'b1, r, x);
    return int'(plug_map[x]) % Alphabet;
  endfunction

  task automatic run_command(input rcm_item_t cmd, output rcm_result_t res);
    bit bad;
    int cipher;
    int idx;
    int val;
    bad = 1'b0;
    cipher = 0;
    idx = int'(cmd.table_index);
    val = int'(cmd.table_value);
    case (cmd.op)
      OpEncode: begin
        if (cmd.letter >= Alphabet) begin
          bad = 1'b1;
        end else begin
          advance_wheels();
          cipher = encipher(cmd.letter);
        end
      end
      OpStepFwd:  advance_wheels();
      OpStepBack: retreat_wheels();
      OpLoad: begin
        if (idx >= Alphabet || val >= Alphabet || cmd.table_select > SelRefl)
          bad = 1'b1;
        else if (cmd.table_select == SelPlug)
          plug_map[idx] = 5'(val);
        else if (cmd.table_select == SelRefl)
          refl_map[idx] = 5'(val);
        else if (cmd.table_select <= SelFwdLast)
          fwd_map[cmd.table_select - SelFwdFirst][idx] = 5'(val);
        else
          inv_map[cmd.table_select - SelInvFirst][idx] = 5'(val);
      end
      OpSetPos: begin
        if (cmd.position_value >= Alphabet)
          bad = 1'b1;
        else
          wheel_pos[cmd.rotor_select] = cmd.position_value;
      end
      default: bad = 1'b1;
    endcase
    res.cipher_letter   = 5'(cipher);
    res.fast_position   = wheel_pos[0];
    res.middle_position = wheel_pos[1];
    res.slow_position   = wheel_pos[2];
    res.fourth_position = wheel_pos[3];
    res.input_error     = bad;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    rcm_item_t   cmd;
    rcm_result_t want;
    rcm_result_t got;
    if (!rst_ni) begin
      rotor_count    = 3'd3;
      ring_word      = '0;
      fast_notches   = '0;
      middle_notches = '0;
      for (int r = 0; r < NumPos; r++)
        wheel_pos[r] = '0;
      predicted_q.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          CfgRotorCount:  rotor_count    = cfg_data_i[2:0];
          CfgRingOffsets: ring_word      = cfg_data_i[19:0];
          CfgFastNotch:   fast_notches   = cfg_data_i[25:0];
          CfgMiddleNotch: middle_notches = cfg_data_i[25:0];
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) begin
        cmd = rcm_item_t'(s_axis_tdata[$bits(rcm_item_t)-1:0]);
        run_command(cmd, want);
        predicted_q.push_back(want);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got = rcm_result_t'(m_axis_tdata[$bits(rcm_result_t)-1:0]);
        if (predicted_q.size() == 0) begin
          flag("unexpected result", int'(got), 0);
        end else begin
          want = predicted_q.pop_front();
          if (got.cipher_letter !== want.cipher_letter)
            flag("cipher_letter", got.cipher_letter, want.cipher_letter);
          if (got.fast_position !== want.fast_position)
            flag("fast_position", got.fast_position, want.fast_position);
          if (got.middle_position !== want.middle_position)
            flag("middle_position", got.middle_position, want.middle_position);
          if (got.slow_position !== want.slow_position)
            flag("slow_position", got.slow_position, want.slow_position);
          if (got.fourth_position !== want.fourth_position)
            flag("fourth_position", got.fourth_position, want.fourth_position);
          if (got.input_error !== want.input_error)
            flag("input_error", got.input_error, want.input_error);
        end
      end
    end
    // publish after the edge so readers at the next edge see this edge's work
    pending_o    <= predicted_q.size();
    mismatches_o <= mismatch_count;
  end

endmodule

[tb/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: stimulus and verdict for rotor_cipher_machine
// Programs the registers between phases, sends rejected commands, fills
// every wiring table, runs directed stepping and encode cases, then random
// command mixes under several register settings with random stalls on both
// streams. Checking is done by rcm_checker beside the block.
// ----------------------------------------------------------------------------
module tb;
  import rcm_pkg::*;

  localparam int Alphabet    = 26;
  localparam int FieldTop    = 31;        // largest 5-bit field value
  localparam int SelTop      = 15;        // largest table_select value
  localparam logic [2:0] OpTop = 3'b111;  // highest op code, unused by the block
  localparam int ItemW       = $bits(rcm_item_t);
  localparam int IdlePct     = 38;
  localparam int HoldAt      = 500;       // result count that starts the long hold-off
  localparam int HoldCycles  = 300;
  localparam int QuietFrom   = 700;       // result window with tready held high
  localparam int QuietTo     = 800;
  localparam int DrainCycles = 32;        // well above the longest encode latency
  localparam int Limit       = 600000;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [TdataW-1:0]   s_axis_tdata  = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [TdataW-1:0]   m_axis_tdata;
  logic                cfg_valid_i   = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i   = '0;
  logic [CfgDataW-1:0] cfg_data_i    = '0;

  int mismatches;
  int pending;
  int cycles;
  bit tx_steady;   // sender offers back to back while set

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  rotor_cipher_machine dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  rcm_checker u_check (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .mismatches_o  (mismatches),
    .pending_o     (pending)
  );

  // Drop the command stream and wait until every predicted result has been
  // seen. The first edge lets the checker's count catch up with any transfer
  // at the edge the caller returned from.
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(rcm_cfg_e idx, logic [CfgDataW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  // Program all four registers with the block idle. Unused upper data bits
  // carry random filler; the block must ignore them.
  task automatic program_regs(logic [2:0] count, logic [19:0] rings,
                              logic [25:0] fast, logic [25:0] middle);
    logic [CfgDataW-1:0] filler;
    filler = CfgDataW'($urandom);
    wait_drained();
    repeat (DrainCycles) @(posedge clk_i);
    write_reg(CfgRotorCount, {filler[CfgDataW-1:3], count});
    write_reg(CfgRingOffsets, {filler[CfgDataW-1:20], rings});
    write_reg(CfgFastNotch, fast);
    write_reg(CfgMiddleNotch, middle);
    cfg_valid_i <= 1'b0;
  endtask

  // Offer one command; valid stays high after the transfer so the next
  // command can follow back to back.
  task automatic send(rcm_item_t cmd);
    if (!tx_steady) begin
      while ($urandom_range(99) < IdlePct) begin
        s_axis_tvalid <= 1'b0;
        @(posedge clk_i);
      end
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= TdataW'(cmd);
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // Command with the given op and random content in every other field.
  function automatic rcm_item_t shaped(logic [2:0] op);
    rcm_item_t cmd;
    cmd    = rcm_item_t'(ItemW'($urandom));
    cmd.op = op;
    return cmd;
  endfunction

  task automatic send_plain(logic [2:0] op);
    send(shaped(op));
  endtask

  task automatic send_encode(int letter);
    rcm_item_t cmd;
    cmd        = shaped(OpEncode);
    cmd.letter = 5'(letter);
    send(cmd);
  endtask

  task automatic send_load(int sel, int idx, int val);
    rcm_item_t cmd;
    cmd              = shaped(OpLoad);
    cmd.table_select = 4'(sel);
    cmd.table_index  = 5'(idx);
    cmd.table_value  = 5'(val);
    send(cmd);
  endtask

  task automatic send_setpos(int r, int val);
    rcm_item_t cmd;
    cmd                = shaped(OpSetPos);
    cmd.rotor_select   = 2'(r);
    cmd.position_value = 5'(val);
    send(cmd);
  endtask

  // Mostly well-formed traffic, encode heavy, with a share of rejects.
  function automatic rcm_item_t any_command();
    rcm_item_t cmd;
    int pick;
    pick = $urandom_range(99);
    if (pick < 48) begin
      cmd = shaped(OpEncode);
      cmd.letter = ($urandom_range(15) == 0) ? 5'($urandom_range(FieldTop, Alphabet))
                                             : 5'($urandom_range(Alphabet - 1));
    end else if (pick < 58) begin
      cmd = shaped(OpStepFwd);
    end else if (pick < 68) begin
      cmd = shaped(OpStepBack);
    end else if (pick < 80) begin
      cmd = shaped(OpLoad);
      cmd.table_select = ($urandom_range(7) == 0) ? 4'($urandom_range(SelTop, SelRefl + 1))
                                                  : 4'($urandom_range(SelRefl));
      if ($urandom_range(9) != 0) cmd.table_index = 5'($urandom_range(Alphabet - 1));
      if ($urandom_range(9) != 0) cmd.table_value = 5'($urandom_range(Alphabet - 1));
    end else if (pick < 92) begin
      cmd = shaped(OpSetPos);
      if ($urandom_range(7) != 0) cmd.position_value = 5'($urandom_range(Alphabet - 1));
    end else begin
      cmd = shaped(3'($urandom_range(OpTop, 3'(OpSetPos) + 3'd1)));
    end
    return cmd;
  endfunction

  task automatic random_phase(int count);
    repeat (count) send(any_command());
  endtask

  // Result side: random stalls, one long hold-off while the sender keeps
  // offering, and a window with tready held high.
  initial begin : sink
    int  taken;
    bit  held;
    taken = 0;
    held  = 1'b0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) taken++;
      if (!held && taken >= HoldAt) begin
        held = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
      end else begin
        m_axis_tready <= (taken >= QuietFrom && taken < QuietTo) ||
                         ($urandom_range(99) >= IdlePct);
      end
    end
  end

  // Hard stop if the block hangs.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= Limit) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin : stimulus
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // classic notch layout for the directed part
    program_regs(3'd3, '0, 26'(1) << 16, 26'(1) << 4);

    // Rejected commands, legal before any table is loaded: unknown ops,
    // bad letters, bad table select, index or value, bad position.
    send_plain(OpTop);
    send_plain(3'(OpSetPos) + 3'd1);
    send_encode(Alphabet);
    send_encode(FieldTop);
    send_load(SelRefl + 1, 0, 0);
    send_load(SelTop, 0, 0);
    send_load(SelPlug, Alphabet, 0);
    send_load(SelPlug, FieldTop, 0);
    send_load(SelFwdFirst, 0, Alphabet);
    send_load(SelInvLast, 0, FieldTop);
    send_setpos(0, Alphabet);
    send_setpos(NumPos - 1, FieldTop);

    // position extremes and wrap in both directions
    send_setpos(0, Alphabet - 1);
    send_setpos(NumPos - 1, Alphabet - 1);
    send_plain(OpStepFwd);
    send_plain(OpStepBack);
    send_plain(OpStepBack);

    // Load every entry of every table before the first encode.
    for (int s = SelPlug; s <= SelRefl; s++) begin
      for (int i = 0; i < Alphabet; i++)
        send_load(s, i, $urandom_range(Alphabet - 1));
    end

    // Fast rotor on its notch carries the middle; next encode double steps
    // the middle and carries the slow rotor across its wrap.
    send_setpos(0, 16);
    send_setpos(1, 3);
    send_setpos(2, Alphabet - 1);
    send_setpos(3, 0);
    send_encode(0);
    send_encode(Alphabet - 1);
    send_plain(OpStepBack);
    send_plain(OpStepBack);
    send_encode(12);
    send_setpos(0, Alphabet - 1);
    send_encode(13);

    // Random phases, each under its own register setting.
    program_regs(3'd0, '1, '1, '0);
    random_phase(90);
    program_regs(3'd7, {4{5'(Alphabet - 1)}}, '0, '1);
    random_phase(90);

    // back to back offers; the long result hold-off lands here
    program_regs(3'd4, 20'($urandom), 26'($urandom), 26'($urandom));
    tx_steady = 1'b1;
    random_phase(110);
    tx_steady = 1'b0;

    program_regs(3'd1, '0, 26'(1) << $urandom_range(Alphabet - 1),
                 26'(1) << $urandom_range(Alphabet - 1));
    random_phase(45);
    wait_drained();
    random_phase(45);

    program_regs(3'd2, 20'($urandom), 26'h2000001, 26'h2000001);
    random_phase(90);
    program_regs(3'd3, 20'($urandom), 26'($urandom), 26'($urandom));
    random_phase(92);

    wait_drained();
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
